@@ rtl/core/dad_pkg.sv @@
// ============================================================================
// dad_pkg: shared types, constants and tables of the date arithmetic block
// Holds the transfer payloads, the control word format, the microprogram and
// the small calendar functions used by the datapath.
// ============================================================================
package dad_pkg;

    // Default top year; results beyond it saturate.
    localparam int unsigned MAX_YEAR_DEFAULT = 9999;

    // Field widths fixed by the item formats.
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YIN_W   = 14;
    localparam int unsigned ADD_W   = 20;
    localparam int unsigned COUNT_W = 22;
    localparam int unsigned ERR_W   = 2;

    // Internal widths: walked year, days still to place, accumulated days.
    localparam int unsigned YEAR_W  = 16;
    localparam int unsigned REM_W   = 21;
    localparam int unsigned ACC_W   = 23;
    localparam int unsigned TOTAL_W = 24;
    localparam int unsigned M400_W  = 9;
    localparam int unsigned STEP_W  = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Calendar constants.
    localparam logic [DAY_W-1:0]   DAYS_28   = 5'd28;
    localparam logic [DAY_W-1:0]   DAYS_29   = 5'd29;
    localparam logic [DAY_W-1:0]   DAYS_30   = 5'd30;
    localparam logic [DAY_W-1:0]   DAYS_31   = 5'd31;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [M400_W-1:0]  M400_LAST = 9'd399;
    localparam logic [M400_W-1:0]  M400_100  = 9'd100;
    localparam logic [M400_W-1:0]  M400_200  = 9'd200;
    localparam logic [M400_W-1:0]  M400_300  = 9'd300;

    // Error codes of a result.
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

    // Input item.
    typedef struct packed {
        logic               command;
        logic [DAY_W-1:0]   day_a;
        logic [MONTH_W-1:0] month_a;
        logic [YIN_W-1:0]   year_a;
        logic [DAY_W-1:0]   day_b;
        logic [MONTH_W-1:0] month_b;
        logic [YIN_W-1:0]   year_b;
        logic [ADD_W-1:0]   add_days;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [DAY_W-1:0]   res_day;
        logic [MONTH_W-1:0] res_month;
        logic [YIN_W-1:0]   res_year;
        logic [COUNT_W-1:0] day_count;
        logic [ERR_W-1:0]   error;
    } out_item_t;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD_ADD,
        OP_LOAD_DIFF,
        OP_ADD_STEP,
        OP_DIFF_STEP,
        OP_OUT_ADD,
        OP_OUT_DIFF,
        OP_OUT_RANGE,
        OP_OUT_OVERFLOW,
        OP_OUT_SAT
    } op_t;

    // Jump conditions.
    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_CMD_DIFF,
        COND_BAD_A,
        COND_BAD_AB,
        COND_YA_OVER,
        COND_YEARS_OVER,
        COND_B_LATER,
        COND_ADD_DONE,
        COND_DIFF_DONE,
        COND_OUT_BUSY
    } cond_t;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic cmd_diff;
        logic bad_a;
        logic bad_ab;
        logic ya_over;
        logic years_over;
        logic b_later;
        logic add_done;
        logic diff_done;
        logic out_busy;
    } flags_t;

    // One control word: when the condition holds the step jumps and its
    // operation is skipped, otherwise the operation runs and control falls
    // through to the second address.
    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] jump_to;
        logic [STEP_W-1:0] fall_to;
    } ucode_t;

    // Program addresses.
    localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DISPATCH  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ADD_CHK   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ADD_LOAD  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ADD_LOOP  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ADD_END   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DIFF_CHK  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DIFF_YRS  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DIFF_LOAD = 4'd8;
    localparam logic [STEP_W-1:0] STEP_DIFF_LOOP = 4'd9;
    localparam logic [STEP_W-1:0] STEP_RANGE     = 4'd10;
    localparam logic [STEP_W-1:0] STEP_SAT       = 4'd11;
    localparam logic [STEP_W-1:0] STEP_OVERFLOW  = 4'd12;
    localparam logic [STEP_W-1:0] STEP_DIFF_END  = 4'd13;

    // The microprogram.
    function automatic ucode_t ucode_word(input logic [STEP_W-1:0] addr);
        case (addr)
            STEP_IDLE:      return '{OP_CAPTURE, COND_NO_INPUT, STEP_IDLE, STEP_DISPATCH};
            STEP_DISPATCH:  return '{OP_NONE, COND_CMD_DIFF, STEP_DIFF_CHK, STEP_ADD_CHK};
            STEP_ADD_CHK:   return '{OP_NONE, COND_BAD_A, STEP_RANGE, STEP_ADD_LOAD};
            STEP_ADD_LOAD:  return '{OP_LOAD_ADD, COND_YA_OVER, STEP_SAT, STEP_ADD_LOOP};
            STEP_ADD_LOOP:  return '{OP_ADD_STEP, COND_ADD_DONE, STEP_ADD_END, STEP_ADD_LOOP};
            STEP_ADD_END:   return '{OP_OUT_ADD, COND_OUT_BUSY, STEP_ADD_END, STEP_IDLE};
            STEP_DIFF_CHK:  return '{OP_NONE, COND_BAD_AB, STEP_RANGE, STEP_DIFF_YRS};
            STEP_DIFF_YRS:  return '{OP_NONE, COND_YEARS_OVER, STEP_OVERFLOW, STEP_DIFF_LOAD};
            STEP_DIFF_LOAD: return '{OP_LOAD_DIFF, COND_B_LATER, STEP_RANGE, STEP_DIFF_LOOP};
            STEP_DIFF_LOOP: return '{OP_DIFF_STEP, COND_DIFF_DONE, STEP_DIFF_END,
                                     STEP_DIFF_LOOP};
            STEP_RANGE:     return '{OP_OUT_RANGE, COND_OUT_BUSY, STEP_RANGE, STEP_IDLE};
            STEP_SAT:       return '{OP_OUT_SAT, COND_OUT_BUSY, STEP_SAT, STEP_IDLE};
            STEP_OVERFLOW:  return '{OP_OUT_OVERFLOW, COND_OUT_BUSY, STEP_OVERFLOW,
                                     STEP_IDLE};
            STEP_DIFF_END:  return '{OP_OUT_DIFF, COND_OUT_BUSY, STEP_DIFF_END, STEP_IDLE};
            default:        return '{OP_NONE, COND_ALWAYS, STEP_IDLE, STEP_IDLE};
        endcase
    endfunction

    // Year modulo 400 by six restoring compare-and-subtract steps.
    function automatic logic [M400_W-1:0] year_mod_400(input logic [YIN_W-1:0] year);
        logic [YIN_W:0] rest;
        rest = {1'b0, year};
        for (int k = 5; k >= 0; k--) begin
            if (rest >= (YIN_W+1)'(400 << k)) begin
                rest = rest - (YIN_W+1)'(400 << k);
            end
        end
        return rest[M400_W-1:0];
    endfunction

    // Length of a month, given whether the year is a leap year.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        case (month)
            MONTH_FEB: return leap ? DAYS_29 : DAYS_28;
            MONTH_APR,
            MONTH_JUN,
            MONTH_SEP,
            MONTH_NOV: return DAYS_30;
            default:   return DAYS_31;
        endcase
    endfunction

endpackage

@@ rtl/core/dad_stream_if.sv @@
// ============================================================================
// dad_stream_if: valid/ready channel
// Carries one payload per transfer; a transfer completes on a rising clock
// edge with valid and ready both high.
// ============================================================================
interface dad_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ rtl/core/dad_sequencer.sv @@
// ============================================================================
// dad_sequencer: step counter and microprogram of the date arithmetic block
// Reads one control word per cycle, evaluates its jump condition against the
// datapath flags and issues the operation for the datapath.
// ============================================================================
module dad_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  dad_pkg::flags_t flags,
    output dad_pkg::op_t    op,
    output logic            idle
);
    import dad_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            word;
    logic              taken;

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Condition select, next step and gated operation.
    always_comb
    begin
        word = ucode_word(step_reg);
        case (word.cond)
            COND_ALWAYS:     taken = 1'b1;
            COND_NO_INPUT:   taken = !flags.in_valid;
            COND_CMD_DIFF:   taken = flags.cmd_diff;
            COND_BAD_A:      taken = flags.bad_a;
            COND_BAD_AB:     taken = flags.bad_ab;
            COND_YA_OVER:    taken = flags.ya_over;
            COND_YEARS_OVER: taken = flags.years_over;
            COND_B_LATER:    taken = flags.b_later;
            COND_ADD_DONE:   taken = flags.add_done;
            COND_DIFF_DONE:  taken = flags.diff_done;
            COND_OUT_BUSY:   taken = flags.out_busy;
            default:         taken = 1'b1;
        endcase
        step_next = taken ? word.jump_to : word.fall_to;
        op        = taken ? OP_NONE : word.op;
    end

    assign idle = (step_reg == STEP_IDLE);

endmodule

@@ rtl/core/dad_datapath.sv @@
// ============================================================================
// dad_datapath: working registers and result register of the date block
// Holds the captured item, the month walk (days left, month, year, year
// modulo 400, accumulated days) and the output register, and reports the
// flags on which the microprogram branches.
// ============================================================================
module dad_datapath #(
    parameter int unsigned MAX_YEAR = dad_pkg::MAX_YEAR_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  dad_pkg::op_t    op,
    input  logic            idle,
    output dad_pkg::flags_t flags,
    dad_stream_if.sink      request,
    dad_stream_if.source    result
);
    import dad_pkg::*;

    localparam logic [YEAR_W-1:0] MAX_YEAR_W = YEAR_W'(MAX_YEAR);

    in_item_t           item_reg, item_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [M400_W-1:0]  m400_reg, m400_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    out_item_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               leap;
    logic [DAY_W-1:0]   len;
    logic               wrap;
    logic [MONTH_W-1:0] month_adv;
    logic [YEAR_W-1:0]  year_adv;
    logic [M400_W-1:0]  m400_adv;
    logic               walk_over;
    logic               bad_b;
    logic               yb_over;
    logic [TOTAL_W-1:0] total_days;
    logic [TOTAL_W-1:0] diff_days;
    logic               diff_neg;
    logic               diff_big;
    out_item_t          sat_item;

    // Month length at the walk position, Gregorian leap rule.
    assign leap = (year_reg[1:0] == 2'b00) && (m400_reg != M400_100)
                  && (m400_reg != M400_200) && (m400_reg != M400_300);
    assign len  = month_len(month_reg, leap);

    // Advance of the walk by one month, wrapping the year after December.
    assign wrap      = (month_reg == MONTH_DEC);
    assign month_adv = wrap ? MONTH_JAN : month_reg + MONTH_W'(1);
    assign year_adv  = wrap ? year_reg + YEAR_W'(1) : year_reg;
    assign m400_adv  = !wrap ? m400_reg
                     : (m400_reg == M400_LAST) ? '0 : m400_reg + M400_W'(1);
    assign walk_over = (year_reg > MAX_YEAR_W);

    // Final count of a difference.
    assign total_days = TOTAL_W'(acc_reg) + TOTAL_W'(item_reg.day_a);
    assign diff_neg   = (total_days < TOTAL_W'(item_reg.day_b));
    assign diff_days  = total_days - TOTAL_W'(item_reg.day_b);
    assign diff_big   = (diff_days > TOTAL_W'(COUNT_MAX));

    // Saturated date returned on year overflow.
    assign sat_item = '{res_day: DAYS_31, res_month: MONTH_DEC,
                        res_year: MAX_YEAR_W[YIN_W-1:0], day_count: '0,
                        error: ERR_OVERFLOW};

    // Branch flags.
    assign bad_b   = (item_reg.month_b == '0) || (item_reg.month_b > MONTH_DEC);
    assign yb_over = (YEAR_W'(item_reg.year_b) > MAX_YEAR_W);
    always_comb
    begin
        flags.in_valid   = request.valid;
        flags.cmd_diff   = item_reg.command;
        flags.bad_a      = (item_reg.month_a == '0) || (item_reg.month_a > MONTH_DEC);
        flags.bad_ab     = flags.bad_a || bad_b;
        flags.ya_over    = (YEAR_W'(item_reg.year_a) > MAX_YEAR_W);
        flags.years_over = flags.ya_over || yb_over;
        flags.b_later    = (item_reg.year_b > item_reg.year_a)
                           || ((item_reg.year_b == item_reg.year_a)
                               && ((item_reg.month_b > item_reg.month_a)
                                   || ((item_reg.month_b == item_reg.month_a)
                                       && (item_reg.day_b > item_reg.day_a))));
        flags.add_done   = (rem_reg <= REM_W'(len)) || walk_over;
        flags.diff_done  = (month_reg == item_reg.month_a)
                           && (year_reg == YEAR_W'(item_reg.year_a));
        flags.out_busy   = out_valid_reg && !result.ready;
    end

    // Operation decode.
    always_comb
    begin
        item_next      = item_reg;
        rem_next       = rem_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        m400_next      = m400_reg;
        acc_next       = acc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        case (op)
            OP_CAPTURE:
            begin
                item_next = request.data;
            end
            OP_LOAD_ADD:
            begin
                rem_next   = REM_W'(item_reg.add_days) + REM_W'(item_reg.day_a);
                month_next = item_reg.month_a;
                year_next  = YEAR_W'(item_reg.year_a);
                m400_next  = year_mod_400(item_reg.year_a);
            end
            OP_LOAD_DIFF:
            begin
                month_next = item_reg.month_b;
                year_next  = YEAR_W'(item_reg.year_b);
                m400_next  = year_mod_400(item_reg.year_b);
                acc_next   = '0;
            end
            OP_ADD_STEP:
            begin
                rem_next   = rem_reg - REM_W'(len);
                month_next = month_adv;
                year_next  = year_adv;
                m400_next  = m400_adv;
            end
            OP_DIFF_STEP:
            begin
                acc_next   = acc_reg + ACC_W'(len);
                month_next = month_adv;
                year_next  = year_adv;
                m400_next  = m400_adv;
            end
            OP_OUT_ADD:
            begin
                if (walk_over)
                begin
                    out_next = sat_item;
                end
                else
                begin
                    out_next = '{res_day: rem_reg[DAY_W-1:0], res_month: month_reg,
                                 res_year: year_reg[YIN_W-1:0], day_count: '0,
                                 error: ERR_NONE};
                end
                out_valid_next = 1'b1;
            end
            OP_OUT_DIFF:
            begin
                out_next = '0;
                if (diff_neg)
                begin
                    out_next.error = ERR_RANGE;
                end
                else if (diff_big)
                begin
                    out_next.day_count = COUNT_MAX;
                    out_next.error     = ERR_OVERFLOW;
                end
                else
                begin
                    out_next.day_count = diff_days[COUNT_W-1:0];
                end
                out_valid_next = 1'b1;
            end
            OP_OUT_RANGE:
            begin
                out_next       = '0;
                out_next.error = ERR_RANGE;
                out_valid_next = 1'b1;
            end
            OP_OUT_OVERFLOW:
            begin
                out_next       = '0;
                out_next.error = ERR_OVERFLOW;
                out_valid_next = 1'b1;
            end
            OP_OUT_SAT:
            begin
                out_next       = sat_item;
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control and walk registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
            month_reg     <= MONTH_JAN;
            year_reg      <= '0;
            m400_reg      <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            m400_reg      <= m400_next;
            acc_reg       <= acc_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

    assign request.ready = idle;
    assign result.valid  = out_valid_reg;
    assign result.data   = out_reg;

endmodule

@@ rtl/core/date_add_and_difference.sv @@
// ============================================================================
// date_add_and_difference: Gregorian date add and day difference
// Microcoded sequencer over a month-walking datapath.
// ============================================================================
// Usage:
// The request channel carries one item per transfer: the command, dates A
// and B and the days to add. The result channel returns exactly one item per
// request: the resulting date, the day count and an error code.
// An add walks the months onward from date A; a difference walks the
// months from B to A. Rejected items (bad month, year beyond the top year,
// B later than A) skip the walk. The month walk does one month per cycle,
// in a loop step of its own for each command, so the largest add walks
// about 34,500 months. A new request can be taken as soon as a result has
// been written to the output register.
// While the receiver stalls, the result waits in the output register; the
// block takes and works the next request meanwhile and holds at its result
// step until the register is free.
// After reset the sequencer is at its idle step with the output empty.
// ============================================================================
module date_add_and_difference #(
    parameter int unsigned MAX_YEAR = dad_pkg::MAX_YEAR_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    dad_stream_if.sink   request,
    dad_stream_if.source result
);
    import dad_pkg::*;

    op_t    op;
    flags_t flags;
    logic   idle;

    // Microprogram sequencer.
    dad_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op),
        .idle  (idle)
    );

    // Walk datapath and output register.
    dad_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .idle    (idle),
        .flags   (flags),
        .request (request),
        .result  (result)
    );

    // A request transfer leads to the dispatch step, so the next cycle is never idle.
    a_busy_after_transfer : assert property (
        @(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready
    ) else $error("request taken again straight after a transfer");

    // A range error carries no date and no count.
    a_range_zero : assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && (result.data.error == ERR_RANGE))
        |-> ((result.data.res_day == '0) && (result.data.res_month == '0)
             && (result.data.res_year == '0) && (result.data.day_count == '0))
    ) else $error("range error with non-zero result fields");

    // Only the three defined error codes are produced.
    a_err_code : assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.data.error <= ERR_OVERFLOW)
    ) else $error("undefined error code");

    // A good result never names a month beyond December.
    a_month_ok : assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && (result.data.error == ERR_NONE))
        |-> (result.data.res_month <= MONTH_DEC)
    ) else $error("result month out of range");

endmodule
